// ===== rtl/core/lbps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED bar pattern sequencer package
// Mode codes, pattern constants and the item types shared by the block.
// ----------------------------------------------------------------------------
package lbps_pkg;

  typedef enum logic [3:0] {
    MODE_OFF       = 4'd0,
    MODE_STATIC    = 4'd1,
    MODE_ALTERNATE = 4'd2,
    MODE_UP        = 4'd3,
    MODE_BOUNCE    = 4'd4,
    MODE_DOWN      = 4'd5,
    MODE_WALK_ONE  = 4'd6,
    MODE_WALK_ZERO = 4'd7,
    MODE_FILL      = 4'd8
  } mode_t;

  localparam logic [7:0] CMD_MAX = 8'd8;

  localparam logic       FUNC_TICK    = 1'b0;
  localparam logic       FUNC_COMMAND = 1'b1;

  localparam logic [7:0] PAT_OFF  = 8'h00;
  localparam logic [7:0] PAT_EVEN = 8'h55;
  localparam logic [7:0] PAT_ODD  = 8'hAA;
  localparam logic [7:0] PAT_ALL  = 8'hFF;

  localparam logic [7:0] DOWN_RELOAD = 8'd255;
  localparam logic [2:0] BOUNCE_LAST = 3'd6;

  typedef struct packed {
    logic       func;
    logic [7:0] command_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic logic [7:0] bounce_pattern(input logic [2:0] step);
    logic [7:0] p;
    case (step)
      3'd0:    p = 8'h18;
      3'd1:    p = 8'h24;
      3'd2:    p = 8'h42;
      3'd3:    p = 8'h81;
      3'd4:    p = 8'h42;
      3'd5:    p = 8'h24;
      3'd6:    p = 8'h18;
      default: p = PAT_OFF;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/lbps_if.sv =====
// ----------------------------------------------------------------------------
// LED bar pattern sequencer channels
// Valid/ready channel interfaces for command/tick items and LED patterns.
// ----------------------------------------------------------------------------
interface lbps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] command_byte;

  modport source(output valid, output func, output command_byte, input ready);
  modport sink(input valid, input func, input command_byte, output ready);
endinterface

interface lbps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_pattern;

  modport source(output valid, output led_pattern, input ready);
  modport sink(input valid, input led_pattern, output ready);
endinterface

// ===== rtl/core/lbps_in_stage.sv =====
// ----------------------------------------------------------------------------
// LED bar input register
// Captures one item per cycle, but stalls while a held item is not yet taken.
// ----------------------------------------------------------------------------
module lbps_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lbps_pkg::item_t     in_item,
  output logic                in_ready,
  input  logic                advance,
  output lbps_pkg::stage_t    stage
);

  logic            valid;
  lbps_pkg::item_t item;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ===== rtl/core/lbps_mode_engine.sv =====
// ----------------------------------------------------------------------------
// LED bar mode engine
// Holds the active mode and the per-mode step counters, forms the pattern.
// ----------------------------------------------------------------------------
module lbps_mode_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  lbps_pkg::item_t item,
  output logic [7:0]      pattern
);

  lbps_pkg::mode_t active_mode;
  lbps_pkg::mode_t active_mode_next;
  logic [2:0] alternate_step, alternate_step_next;
  logic [7:0] up_count, up_count_next;
  logic [2:0] bounce_step, bounce_step_next;
  logic [7:0] down_count, down_count_next;
  logic [2:0] walk_one_step, walk_one_step_next;
  logic [2:0] walk_zero_step, walk_zero_step_next;
  logic [2:0] fill_step, fill_step_next;
  logic [7:0] one_hot;
  logic       cmd_ok;
  logic [3:0] cmd_mode;

  assign one_hot  = 8'd1 << walk_one_step;
  assign cmd_ok   = item.command_byte <= lbps_pkg::CMD_MAX;
  assign cmd_mode = item.command_byte[3:0];

  always_comb begin
    case (active_mode)
      lbps_pkg::MODE_STATIC:    pattern = lbps_pkg::PAT_EVEN;
      lbps_pkg::MODE_ALTERNATE: pattern = alternate_step[0] ? lbps_pkg::PAT_ODD
                                                            : lbps_pkg::PAT_EVEN;
      lbps_pkg::MODE_UP:        pattern = up_count;
      lbps_pkg::MODE_BOUNCE:    pattern = lbps_pkg::bounce_pattern(bounce_step);
      lbps_pkg::MODE_DOWN:      pattern = down_count;
      lbps_pkg::MODE_WALK_ONE:  pattern = one_hot;
      lbps_pkg::MODE_WALK_ZERO: pattern = ~(8'd1 << walk_zero_step);
      lbps_pkg::MODE_FILL:      pattern = (8'd2 << fill_step) - 8'd1;
      default:                  pattern = lbps_pkg::PAT_OFF;
    endcase
  end

  always_comb begin
    active_mode_next    = active_mode;
    alternate_step_next = alternate_step;
    up_count_next       = up_count;
    bounce_step_next    = bounce_step;
    down_count_next     = down_count;
    walk_one_step_next  = walk_one_step;
    walk_zero_step_next = walk_zero_step;
    fill_step_next      = fill_step;
    if (item.func == lbps_pkg::FUNC_COMMAND) begin
      if (cmd_ok) begin
        if (cmd_mode == active_mode) begin
          // Reselecting the running mode restarts its counter.
          case (active_mode)
            lbps_pkg::MODE_ALTERNATE: alternate_step_next = 3'd0;
            lbps_pkg::MODE_UP:        up_count_next       = 8'd0;
            lbps_pkg::MODE_BOUNCE:    bounce_step_next    = 3'd0;
            lbps_pkg::MODE_DOWN:      down_count_next     = lbps_pkg::DOWN_RELOAD;
            lbps_pkg::MODE_WALK_ONE:  walk_one_step_next  = 3'd0;
            lbps_pkg::MODE_WALK_ZERO: walk_zero_step_next = 3'd0;
            lbps_pkg::MODE_FILL:      fill_step_next      = 3'd0;
            default:                  ;
          endcase
        end else begin
          active_mode_next = lbps_pkg::mode_t'(cmd_mode);
        end
      end
    end else begin
      case (active_mode)
        lbps_pkg::MODE_ALTERNATE: alternate_step_next = alternate_step + 3'd1;
        lbps_pkg::MODE_UP:        up_count_next       = up_count + 8'd1;
        lbps_pkg::MODE_BOUNCE:    bounce_step_next    =
            (bounce_step >= lbps_pkg::BOUNCE_LAST) ? 3'd0 : bounce_step + 3'd1;
        lbps_pkg::MODE_DOWN:      down_count_next     =
            (down_count <= 8'd1) ? lbps_pkg::DOWN_RELOAD : down_count - 8'd1;
        lbps_pkg::MODE_WALK_ONE:  walk_one_step_next  = walk_one_step + 3'd1;
        lbps_pkg::MODE_WALK_ZERO: walk_zero_step_next = walk_zero_step + 3'd1;
        lbps_pkg::MODE_FILL:      fill_step_next      = fill_step + 3'd1;
        default:                  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode    <= lbps_pkg::MODE_OFF;
      alternate_step <= 3'd0;
      up_count       <= 8'd0;
      bounce_step    <= 3'd0;
      down_count     <= lbps_pkg::DOWN_RELOAD;
      walk_one_step  <= 3'd0;
      walk_zero_step <= 3'd0;
      fill_step      <= 3'd0;
    end else if (fire) begin
      active_mode    <= active_mode_next;
      alternate_step <= alternate_step_next;
      up_count       <= up_count_next;
      bounce_step    <= bounce_step_next;
      down_count     <= down_count_next;
      walk_one_step  <= walk_one_step_next;
      walk_zero_step <= walk_zero_step_next;
      fill_step      <= fill_step_next;
    end
  end

  // The reload keeps the down counter off zero.
  a_down_nonzero: assert property (@(posedge clk) disable iff (rst)
    down_count != 8'd0)
    else $error("down counter reached zero");

  // The bounce sequence has seven steps.
  a_bounce_range: assert property (@(posedge clk) disable iff (rst)
    bounce_step <= lbps_pkg::BOUNCE_LAST)
    else $error("bounce step out of range");

  a_up_advance: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == lbps_pkg::FUNC_TICK && active_mode == lbps_pkg::MODE_UP
    |=> up_count == $past(up_count) + 8'd1)
    else $error("up counter did not advance on tick");

  a_bad_cmd_ignored: assert property (@(posedge clk) disable iff (rst)
    fire && item.func == lbps_pkg::FUNC_COMMAND && !cmd_ok
    |=> $stable(active_mode))
    else $error("out-of-range command changed the mode");

endmodule

// ===== rtl/core/lbps_out_stage.sv =====
// ----------------------------------------------------------------------------
// LED bar output register
// Holds one pattern item until the downstream side takes it.
// ----------------------------------------------------------------------------
module lbps_out_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic [7:0] pattern,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] led_pattern
);

  logic       valid;
  logic [7:0] data;

  assign can_load    = !valid || out_ready;
  assign out_valid   = valid;
  assign led_pattern = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= pattern;
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> valid && data == $past(pattern))
    else $error("loaded pattern not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    valid && !out_ready |-> !load)
    else $error("pending pattern overwritten");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && out_ready && !load |=> !valid)
    else $error("taken pattern still shown");

endmodule

// ===== rtl/core/led_bar_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED bar pattern sequencer
// A tick item's pattern passes through the input register and then the
// output register, which presents it to the downstream side.
// Throughput: one item per cycle, commands and ticks alike, with no stall
// while the output side takes every pattern.
// Reset (synchronous, rst high): mode off, all step counters zero, down
// counter 255, both registers empty.
// ----------------------------------------------------------------------------
module led_bar_pattern_sequencer (
  input  logic        clk,
  input  logic        rst,
  lbps_in_if.sink     cmd_in,
  lbps_out_if.source  led_out
);

  lbps_pkg::item_t  in_item;
  lbps_pkg::stage_t stage;
  logic             advance;
  logic             can_load;
  logic             load;
  logic [7:0]       pattern;

  assign in_item.func         = cmd_in.func;
  assign in_item.command_byte = cmd_in.command_byte;

  // Commands leave no result, so they never wait on the output register.
  assign advance = stage.valid &&
                   (stage.item.func == lbps_pkg::FUNC_COMMAND || can_load);
  assign load    = advance && stage.item.func == lbps_pkg::FUNC_TICK;

  lbps_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd_in.valid),
    .in_item  (in_item),
    .in_ready (cmd_in.ready),
    .advance  (advance),
    .stage    (stage)
  );

  lbps_mode_engine u_mode_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (advance),
    .item    (stage.item),
    .pattern (pattern)
  );

  lbps_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .pattern     (pattern),
    .can_load    (can_load),
    .out_valid   (led_out.valid),
    .out_ready   (led_out.ready),
    .led_pattern (led_out.led_pattern)
  );

endmodule

// ===== test/tb_led_bar_pattern_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED bar pattern sequencer testbench
// Sends command and tick items through the input channel and keeps a
// behavioral copy of the mode and step counters. Every pattern that
// leaves the block is compared with the oldest predicted pattern. Both
// channels idle and stall at random, with one phase that runs at full rate.
// ----------------------------------------------------------------------------
module tb_led_bar_pattern_sequencer;

  localparam logic [7:0] BOUNCE_SEQ [0:6] = '{
    8'h18, 8'h24, 8'h42, 8'h81, 8'h42, 8'h24, 8'h18
  };

  logic clk = 1'b0;
  logic rst;

  lbps_in_if  cmd_if();
  lbps_out_if led_if();

  led_bar_pattern_sequencer DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_if),
    .led_out (led_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted state of the sequencer.
  lbps_pkg::mode_t cur_mode;
  logic [2:0]      alt_step;
  logic [7:0]      up_cnt;
  logic [2:0]      bounce_step;
  logic [7:0]      down_cnt;
  logic [2:0]      walk1_step;
  logic [2:0]      walk0_step;
  logic [2:0]      fill_step;

  logic [7:0] pending_patterns [$];
  int         err_count = 0;
  bit         src_gaps_on = 1'b1;
  bit         sink_stalls_on = 1'b1;

  task automatic reset_led_state();
    cur_mode    = lbps_pkg::MODE_OFF;
    alt_step    = 3'd0;
    up_cnt      = 8'd0;
    bounce_step = 3'd0;
    down_cnt    = lbps_pkg::DOWN_RELOAD;
    walk1_step  = 3'd0;
    walk0_step  = 3'd0;
    fill_step   = 3'd0;
  endtask

  function automatic void apply_mode_command(input logic [7:0] code);
    lbps_pkg::mode_t m;
    if (code <= lbps_pkg::CMD_MAX) begin
      m = lbps_pkg::mode_t'(code[3:0]);
      if (m != cur_mode) begin
        cur_mode = m;
      end else begin
        // Selecting the active mode again restarts its counter.
        case (m)
          lbps_pkg::MODE_ALTERNATE: alt_step = 3'd0;
          lbps_pkg::MODE_UP:        up_cnt = 8'd0;
          lbps_pkg::MODE_BOUNCE:    bounce_step = 3'd0;
          lbps_pkg::MODE_DOWN:      down_cnt = lbps_pkg::DOWN_RELOAD;
          lbps_pkg::MODE_WALK_ONE:  walk1_step = 3'd0;
          lbps_pkg::MODE_WALK_ZERO: walk0_step = 3'd0;
          lbps_pkg::MODE_FILL:      fill_step = 3'd0;
          default: begin
          end
        endcase
      end
    end
  endfunction

  function automatic logic [7:0] next_led_pattern();
    logic [7:0] p;
    p = lbps_pkg::PAT_OFF;
    case (cur_mode)
      lbps_pkg::MODE_STATIC: begin
        p = lbps_pkg::PAT_EVEN;
      end
      lbps_pkg::MODE_ALTERNATE: begin
        p = alt_step[0] ? lbps_pkg::PAT_ODD : lbps_pkg::PAT_EVEN;
        alt_step = alt_step + 3'd1;
      end
      lbps_pkg::MODE_UP: begin
        p = up_cnt;
        up_cnt = up_cnt + 8'd1;
      end
      lbps_pkg::MODE_BOUNCE: begin
        p = (bounce_step > lbps_pkg::BOUNCE_LAST) ? lbps_pkg::PAT_OFF
                                                  : BOUNCE_SEQ[bounce_step];
        bounce_step = (bounce_step >= lbps_pkg::BOUNCE_LAST) ? 3'd0
                                                             : bounce_step + 3'd1;
      end
      lbps_pkg::MODE_DOWN: begin
        p = down_cnt;
        down_cnt = (down_cnt <= 8'd1) ? lbps_pkg::DOWN_RELOAD : down_cnt - 8'd1;
      end
      lbps_pkg::MODE_WALK_ONE: begin
        p = 8'd1 << walk1_step;
        walk1_step = walk1_step + 3'd1;
      end
      lbps_pkg::MODE_WALK_ZERO: begin
        p = lbps_pkg::PAT_ALL & ~(8'd1 << walk0_step);
        walk0_step = walk0_step + 3'd1;
      end
      lbps_pkg::MODE_FILL: begin
        p = lbps_pkg::PAT_ALL >> (3'd7 - fill_step);
        fill_step = fill_step + 3'd1;
      end
      default: begin
        p = lbps_pkg::PAT_OFF;
      end
    endcase
    return p;
  endfunction

  // Mostly no idle cycles, often a few, now and then a long pause.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted,
  // with valid still high so that the next item can follow without a gap.
  task automatic send_item(input logic f, input logic [7:0] cb);
    int gap;
    gap = src_gaps_on ? idle_cycles() : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= f;
    cmd_if.command_byte <= cb;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    if (f == lbps_pkg::FUNC_COMMAND) begin
      apply_mode_command(cb);
    end else begin
      pending_patterns.push_back(next_led_pattern());
    end
  endtask

  // Output side: ready drops at random for stalls of varying length.
  initial begin
    led_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        led_if.ready <= 1'b0;
        repeat (idle_cycles()) @(posedge clk);
      end else begin
        led_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && led_if.valid && led_if.ready) begin
      if (pending_patterns.size() == 0) begin
        $error("led_pattern: no item expected, actual %h", led_if.led_pattern);
        err_count++;
      end else begin
        if (led_if.led_pattern !== pending_patterns[0]) begin
          $error("led_pattern mismatch: expected %h, actual %h",
                 pending_patterns[0], led_if.led_pattern);
          err_count++;
        end
        void'(pending_patterns.pop_front());
      end
    end
  end

  // Reset patterns of every mode, plus command bytes that must be ignored.
  task automatic test_mode_select();
    send_item(lbps_pkg::FUNC_TICK, 8'h00);
    send_item(lbps_pkg::FUNC_COMMAND, 8'hFF);
    send_item(lbps_pkg::FUNC_COMMAND, lbps_pkg::CMD_MAX + 8'd1);
    send_item(lbps_pkg::FUNC_TICK, 8'hFF);
    for (int m = lbps_pkg::MODE_STATIC; m <= lbps_pkg::MODE_FILL; m++) begin
      send_item(lbps_pkg::FUNC_COMMAND, 8'(m));
      send_item(lbps_pkg::FUNC_TICK, 8'(m));
    end
  endtask

  // Restart of the active mode, then a switch to the up and off modes.
  task automatic test_restart_resume();
    send_item(lbps_pkg::FUNC_COMMAND, 8'(lbps_pkg::MODE_ALTERNATE));
    send_item(lbps_pkg::FUNC_TICK, 8'h00);
    send_item(lbps_pkg::FUNC_COMMAND, 8'(lbps_pkg::MODE_ALTERNATE));
    send_item(lbps_pkg::FUNC_TICK, 8'h00);
    send_item(lbps_pkg::FUNC_COMMAND, 8'(lbps_pkg::MODE_UP));
    send_item(lbps_pkg::FUNC_TICK, 8'h00);
    send_item(lbps_pkg::FUNC_COMMAND, 8'(lbps_pkg::MODE_OFF));
    send_item(lbps_pkg::FUNC_TICK, 8'h00);
  endtask

  // Mode selections followed by runs of ticks. Long runs can carry the up and
  // down counters through their wrap. Ignored commands are not counted.
  task automatic run_mode_sequences(input int n_items);
    int sent;
    int r;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item(lbps_pkg::FUNC_COMMAND,
                  8'($urandom_range(lbps_pkg::CMD_MAX + 1, 255)));
      end else if (r < 14) begin
        send_item(lbps_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_item(lbps_pkg::FUNC_COMMAND, 8'($urandom_range(0, lbps_pkg::CMD_MAX)));
        sent++;
        run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 300)
                                               : $urandom_range(1, 12);
        repeat (run_len) begin
          if ($urandom_range(0, 19) == 0) begin
            send_item(lbps_pkg::FUNC_COMMAND, 8'(cur_mode));
          end else begin
            send_item(lbps_pkg::FUNC_TICK, 8'($urandom_range(0, 255)));
          end
          sent++;
        end
      end
    end
  endtask

  task automatic test_full_rate();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    run_mode_sequences(250);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_mode_sequences(1200);
  endtask

  initial begin
    int waited;
    cmd_if.valid        <= 1'b0;
    cmd_if.func         <= lbps_pkg::FUNC_TICK;
    cmd_if.command_byte <= 8'h00;
    rst                 <= 1'b1;
    reset_led_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_mode_select();
    test_restart_resume();
    test_full_rate();
    test_random_traffic();
    cmd_if.valid <= 1'b0;

    waited = 0;
    while (pending_patterns.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_patterns.size() != 0) begin
      $error("led_pattern: %0d expected items never arrived", pending_patterns.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
